>>> hdl/rsi_pkg.sv
`default_nettype none

package rsi_pkg;

  localparam int MAX_WINDOW = 32;
  localparam int PRICE_BITS = 32;
  localparam int WLEN_BITS  = 6;
  localparam int SLOT_BITS  = $clog2(MAX_WINDOW);
  localparam int TOTAL_BITS = PRICE_BITS + SLOT_BITS;
  localparam int Q_BITS     = 15;
  localparam int NUM_BITS   = TOTAL_BITS + Q_BITS;
  localparam int CNT_BITS   = $clog2(Q_BITS + 1);

  localparam logic [Q_BITS-1:0]    RSI_FULL_SCALE = 15'd25600;
  localparam logic [WLEN_BITS-1:0] WLEN_RESET     = 6'd10;
  localparam logic [WLEN_BITS-1:0] WLEN_MAX       = WLEN_BITS'(MAX_WINDOW);

  typedef struct packed {
    logic [PRICE_BITS-1:0] gain;
    logic [PRICE_BITS-1:0] loss;
  } change_t;

  typedef struct packed {
    logic [NUM_BITS-1:0]   num;
    logic [TOTAL_BITS-1:0] den;
  } div_req_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DROP,
    S_ADD,
    S_PREP,
    S_DIV,
    S_DONE
  } state_t;

  // 25600 * g as shifts and adds: 25600 = 2^14 + 2^13 + 2^10
  function automatic logic [NUM_BITS-1:0] scale_gain(input logic [TOTAL_BITS-1:0] g);
    logic [NUM_BITS-1:0] gx;
    gx = NUM_BITS'(g);
    return (gx << 14) + (gx << 13) + (gx << 10);
  endfunction

endpackage

`default_nettype wire

>>> hdl/rsi_if.sv
`default_nettype none

interface rsi_tick_if import rsi_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [PRICE_BITS-1:0] price;
  logic                  start_of_series;

  modport source (output valid, output price, output start_of_series, input ready);
  modport sink (input valid, input price, input start_of_series, output ready);
endinterface

interface rsi_result_if import rsi_pkg::*;;
  logic              valid;
  logic              ready;
  logic [Q_BITS-1:0] rsi_fixed;
  logic              rsi_valid;

  modport source (output valid, output rsi_fixed, output rsi_valid, input ready);
  modport sink (input valid, input rsi_fixed, input rsi_valid, output ready);
endinterface

interface rsi_cfg_if import rsi_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [WLEN_BITS-1:0] window_length;

  modport source (output valid, output window_length, input ready);
  modport sink (input valid, input window_length, output ready);
endinterface

`default_nettype wire

>>> hdl/rsi_cell.sv
`default_nettype none

module rsi_cell import rsi_pkg::*; (
  input  wire logic    clk,
  input  wire logic    shift,
  input  wire change_t prior,
  output change_t      held
);

  always_ff @(posedge clk) begin
    if (shift) begin
      held <= prior;
    end
  end

endmodule

`default_nettype wire

>>> hdl/rsi_div.sv
`default_nettype none

module rsi_div import rsi_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  input  wire div_req_t req,
  output logic          done,
  output logic [Q_BITS-1:0] quot
);

  localparam logic [CNT_BITS-1:0] STEPS = CNT_BITS'(Q_BITS);

  logic                  busy;
  logic [CNT_BITS-1:0]   count;
  logic [TOTAL_BITS-1:0] rem;
  logic [TOTAL_BITS-1:0] den;
  logic [Q_BITS-1:0]     low;
  logic [TOTAL_BITS:0]   trial;
  logic [TOTAL_BITS:0]   diff;
  logic                  fits;

  assign trial = {rem, low[Q_BITS-1]};
  assign fits  = trial >= {1'b0, den};
  assign diff  = trial - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= STEPS;
      end else if (busy) begin
        count <= count - CNT_BITS'(1);
        if (count == CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Restoring division, one quotient bit per cycle; the high part of the
  // numerator is already below the divisor since the quotient fits Q_BITS.
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= req.num[NUM_BITS-1:Q_BITS];
      low  <= req.num[Q_BITS-1:0];
      den  <= req.den;
      quot <= '0;
    end else if (busy) begin
      rem  <= fits ? diff[TOTAL_BITS-1:0] : trial[TOTAL_BITS-1:0];
      low  <= {low[Q_BITS-2:0], 1'b0};
      quot <= {quot[Q_BITS-2:0], fits};
    end
  end

endmodule

`default_nettype wire

>>> hdl/rsi_window_indicator.sv
`default_nettype none

// RSI over a sliding window of price changes, simple moving average form.
// A price is split into gain and loss as it is accepted. The DROP, ADD and
// PREP states then retire the oldest change from the cell chain, add the new
// change and start the divide. The serial divider makes the 15-bit quotient
// one bit per cycle, and the DONE state loads the output register. When
// the loss total is zero the divide is skipped. Only one price is in work at
// a time: the next price can be taken in the cycle after the result is
// loaded, not before. A finished result waits in the output register while
// the next price is taken. A result stalls in the DONE state only when it
// finds the previous result still waiting in the output register.
// rsi_fixed is 25600*gains/(gains+losses) in Q8, or 25600 when the loss total
// is zero. rsi_valid rises once window_length changes are in the window.
// Writing window_length restarts the window but keeps the last price. A value
// of 0 acts as 1, and values above 32 act as 32.
module rsi_window_indicator import rsi_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  rsi_tick_if.sink      tick,
  rsi_result_if.source  result,
  rsi_cfg_if.sink       cfg
);

  state_t state;
  state_t state_next;

  logic [WLEN_BITS-1:0]  window_eff;
  logic [WLEN_BITS-1:0]  window_last;
  logic [WLEN_BITS-1:0]  items_seen;
  logic [WLEN_BITS-1:0]  items_inc;
  logic [PRICE_BITS-1:0] previous_price;
  logic [TOTAL_BITS-1:0] gain_total;
  logic [TOTAL_BITS-1:0] loss_total;
  change_t               change;
  change_t               change_next;
  change_t               drop;
  logic                  window_full;
  logic                  full_scale;
  logic                  rsi_valid_flag;

  logic                  take;
  logic                  cell_shift;
  logic                  div_start;
  logic                  out_load;
  logic                  div_done;
  logic [Q_BITS-1:0]     div_quot;
  div_req_t              div_req;

  change_t chain [MAX_WINDOW];

  assign take        = tick.valid && tick.ready;
  assign cfg.ready   = 1'b1;
  assign items_inc   = items_seen + WLEN_BITS'(1);
  assign window_last = window_eff - WLEN_BITS'(1);
  assign window_full = items_seen >= window_eff;
  assign drop        = chain[window_last[SLOT_BITS-1:0]];

  always_comb begin
    change_next = '0;
    if (!tick.start_of_series) begin
      if (tick.price > previous_price) begin
        change_next.gain = tick.price - previous_price;
      end else begin
        change_next.loss = previous_price - tick.price;
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (take) state_next = S_DROP;
      S_DROP: state_next = S_ADD;
      S_ADD:  state_next = S_PREP;
      S_PREP: state_next = (loss_total == '0) ? S_DONE : S_DIV;
      S_DIV:  if (div_done) state_next = S_DONE;
      S_DONE: if (!result.valid || result.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    tick.ready = 1'b0;
    cell_shift = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state)
      S_IDLE:  tick.ready = 1'b1;
      S_DROP:  cell_shift = 1'b1;
      S_PREP:  div_start  = (loss_total != '0);
      S_DONE:  out_load   = !result.valid || result.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_eff     <= WLEN_RESET;
      items_seen     <= '0;
      gain_total     <= '0;
      loss_total     <= '0;
      previous_price <= '0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        if (cfg.window_length == '0) begin
          window_eff <= WLEN_BITS'(1);
        end else if (cfg.window_length > WLEN_MAX) begin
          window_eff <= WLEN_MAX;
        end else begin
          window_eff <= cfg.window_length;
        end
        items_seen <= '0;
        gain_total <= '0;
        loss_total <= '0;
      end else begin
        case (state)
          S_IDLE: begin
            if (take) begin
              previous_price <= tick.price;
              if (tick.start_of_series) begin
                items_seen <= '0;
                gain_total <= '0;
                loss_total <= '0;
              end
            end
          end
          S_DROP: begin
            // retire the change that leaves the window
            if (window_full) begin
              gain_total <= gain_total - TOTAL_BITS'(drop.gain);
              loss_total <= loss_total - TOTAL_BITS'(drop.loss);
            end else begin
              items_seen <= items_inc;
            end
          end
          S_ADD: begin
            gain_total <= gain_total + TOTAL_BITS'(change.gain);
            loss_total <= loss_total + TOTAL_BITS'(change.loss);
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      change <= change_next;
    end
    if (state == S_DROP) begin
      rsi_valid_flag <= window_full || (items_inc >= window_eff);
    end
    if (state == S_PREP) begin
      full_scale <= (loss_total == '0);
    end
  end

  assign div_req.num = scale_gain(gain_total);
  assign div_req.den = gain_total + loss_total;

  genvar k;
  generate
    for (k = 0; k < MAX_WINDOW; k++) begin : g_cell
      if (k == 0) begin : g_head
        rsi_cell u_cell (
          .clk   (clk),
          .shift (cell_shift),
          .prior (change),
          .held  (chain[k])
        );
      end else begin : g_body
        rsi_cell u_cell (
          .clk   (clk),
          .shift (cell_shift),
          .prior (chain[k-1]),
          .held  (chain[k])
        );
      end
    end
  endgenerate

  rsi_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .req   (div_req),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (out_load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.rsi_fixed <= full_scale ? RSI_FULL_SCALE : div_quot;
      result.rsi_valid <= rsi_valid_flag;
    end
  end

`ifndef ASSERT_OFF
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    take |=> !tick.ready)
    else $error("price accepted while another is in work");

  a_rsi_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.rsi_fixed <= RSI_FULL_SCALE)
    else $error("rsi_fixed above full scale");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    items_seen <= window_eff)
    else $error("items_seen passed the window length");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider finished outside the divide step");
`endif

endmodule

`default_nettype wire
